/* rtl/cnfcsc_pkg.sv */
// Shared types, field widths and command codes for the CNF clause satisfaction counter.
package cnfcsc_pkg;

    // Fixed field widths of the stream payloads and the configuration register.
    localparam int CLAUSE_COUNT_W = 9;
    localparam int INDEX_W        = 8;
    localparam int MASK_W         = 64;

    // Default sizing of the clause chain.
    localparam int DEF_MAX_CLAUSES   = 256;
    localparam int DEF_MAX_VARIABLES = 64;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Control part of a beat as it travels down the chain.
    typedef struct packed {
        logic               valid;
        logic               command;
        logic [INDEX_W-1:0] clause_index;
    } beat_ctl_t;

endpackage

/* rtl/cnfcsc_cell.sv */
// One clause cell of the chain: stores one clause and scores passing assignments.
module cnfcsc_cell
    import cnfcsc_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int VAR_W      = DEF_MAX_VARIABLES,
    parameter int CNT_W      = CLAUSE_COUNT_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [CNT_W-1:0] used,
    input  beat_ctl_t        ctl_in,
    input  logic [VAR_W-1:0] a_in,
    input  logic [VAR_W-1:0] b_in,
    input  logic [CNT_W-1:0] cnt_in,
    output beat_ctl_t        ctl_out,
    output logic [VAR_W-1:0] a_out,
    output logic [VAR_W-1:0] b_out,
    output logic [CNT_W-1:0] cnt_out
);

    logic [VAR_W-1:0] pos_reg;
    logic [VAR_W-1:0] neg_reg;
    beat_ctl_t        ctl_reg;
    logic [VAR_W-1:0] a_reg;
    logic [VAR_W-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             index_match;
    logic             in_use;
    logic             hit;

    // Decode whether the passing beat addresses or counts this clause.
    assign index_match = (32'(ctl_in.clause_index) == CELL_INDEX);
    assign in_use      = (32'(used) > CELL_INDEX);
    assign hit         = |((a_in & pos_reg) | (~a_in & neg_reg));

    // An evaluate beat picks up one count when this clause is in use and satisfied.
    always_comb begin
        cnt_next = cnt_in;
        if (ctl_in.valid && (ctl_in.command == CMD_EVAL) && in_use && hit) begin
            cnt_next = cnt_in + CNT_W'(1);
        end
    end

    // Control travels with a reset valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    // Payload registers and the clause store need no reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            cnt_reg <= cnt_next;
            if (ctl_in.valid && (ctl_in.command == CMD_LOAD) && index_match) begin
                pos_reg <= a_in;
                neg_reg <= b_in;
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign cnt_out = cnt_reg;

endmodule

/* rtl/cnf_clause_satisfaction_counter.sv */
// Top level of the CNF clause satisfaction counter: input stage, clause chain and result register.
//
// Each clause of the formula lives in its own cell of a chain of MAX_CLAUSES cells. Every
// beat, load or evaluate, walks the chain one cell per cycle while the chain does not stall,
// so loads and evaluations keep their order without any hazard logic. A load beat writes its
// masks into the cell whose index it carries and produces no result; an evaluate beat gathers
// one count in each cell whose clause lies below clause_count and is satisfied. A new beat is
// accepted every cycle unless the chain stalls, and a count passes through every cell register
// and then the result register. The chain stalls only when a finished result reaches its end
// while the previous result still waits on the output. Clause entries hold nothing useful until
// loaded. The user must write clause_count only while no beat is in flight; it is not enforced.
module cnf_clause_satisfaction_counter
    import cnfcsc_pkg::*;
#(
    parameter int MAX_CLAUSES   = DEF_MAX_CLAUSES,
    parameter int MAX_VARIABLES = DEF_MAX_VARIABLES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration: clause_count.
    input  logic                      cfg_wr_en,
    input  logic [CLAUSE_COUNT_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata from bit 0: clause_index[7:0], positive_mask[71:8], negative_mask[135:72],
    // assignment[199:136].
    input  logic [199:0]              s_tdata,
    // tuser from bit 0: command.
    input  logic                      s_tuser,
    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata from bit 0: satisfied_count[8:0], all_satisfied[9], zero fill[15:10].
    output logic [15:0]               m_tdata
);

    localparam int VAR_W = MAX_VARIABLES;
    localparam int CNT_W = $clog2(MAX_CLAUSES + 1);

    logic [CLAUSE_COUNT_W-1:0] clause_count_reg;
    logic [CNT_W-1:0]          used;
    logic                      en;
    logic                      last_eval;
    logic                      out_valid_reg;
    logic [CLAUSE_COUNT_W-1:0] out_count_reg;
    logic                      out_all_reg;

    beat_ctl_t        chain_ctl [0:MAX_CLAUSES];
    logic [VAR_W-1:0] chain_a   [0:MAX_CLAUSES];
    logic [VAR_W-1:0] chain_b   [0:MAX_CLAUSES];
    logic [CNT_W-1:0] chain_cnt [0:MAX_CLAUSES];

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clause_count_reg <= '0;
        end else if (cfg_wr_en) begin
            clause_count_reg <= cfg_wr_data;
        end
    end

    // Clauses in use, clipped to the size of the chain.
    assign used = (32'(clause_count_reg) > MAX_CLAUSES) ? CNT_W'(MAX_CLAUSES)
                                                        : CNT_W'(clause_count_reg);

    // The chain halts only when an evaluate beat at its end cannot move into the result register.
    // No beat is taken while reset is held.
    assign last_eval = chain_ctl[MAX_CLAUSES].valid
                       && (chain_ctl[MAX_CLAUSES].command == CMD_EVAL);
    assign en        = !(last_eval && out_valid_reg && !m_tready);
    assign s_tready  = en && aresetn;

    // Head of the chain: a load carries both masks, an evaluate carries the assignment in slot a.
    always_comb begin
        chain_ctl[0].valid        = s_tvalid && s_tready;
        chain_ctl[0].command      = s_tuser;
        chain_ctl[0].clause_index = s_tdata[INDEX_W-1:0];
        chain_cnt[0]              = '0;
        if (s_tuser == CMD_EVAL) begin
            chain_a[0] = s_tdata[136 +: VAR_W];
        end else begin
            chain_a[0] = s_tdata[8 +: VAR_W];
        end
        chain_b[0] = s_tdata[72 +: VAR_W];
    end

    // The row of clause cells.
    for (genvar k = 0; k < MAX_CLAUSES; k++) begin : g_cell
        cnfcsc_cell #(
            .CELL_INDEX (k),
            .VAR_W      (VAR_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .used    (used),
            .ctl_in  (chain_ctl[k]),
            .a_in    (chain_a[k]),
            .b_in    (chain_b[k]),
            .cnt_in  (chain_cnt[k]),
            .ctl_out (chain_ctl[k+1]),
            .a_out   (chain_a[k+1]),
            .b_out   (chain_b[k+1]),
            .cnt_out (chain_cnt[k+1])
        );
    end

    // Result register: valid bit under reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en && last_eval) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (en && last_eval) begin
            out_count_reg <= CLAUSE_COUNT_W'(chain_cnt[MAX_CLAUSES]);
            out_all_reg   <= (chain_cnt[MAX_CLAUSES] == used);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_all_reg, out_count_reg};

endmodule
